[rtl/core/gkrb_pkg.sv]
`default_nettype none
package gkrb_pkg;

  // field widths
  localparam int SAMPLE_BITS    = 10;
  localparam int THR_BITS       = 10;
  localparam int CMP_BITS       = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int HOLD_BITS      = 5;
  localparam int PHASE_BITS     = 13;
  localparam int BUTTONS        = 4;
  localparam int KEY_BITS       = 8;
  localparam int MOD_BITS       = 2;
  localparam int MODE_BITS      = 2;
  localparam int KEY_SLOTS      = 6;
  localparam int USED_BITS      = $clog2(KEY_SLOTS + 1);
  localparam int SLOT_IDX_BITS  = $clog2(KEY_SLOTS);
  localparam int AXIS_REQS      = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 10;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STRONG_LOW  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEAK_LOW    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEAK_HIGH   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STRONG_HIGH = 3'd4;

  // register reset values
  localparam logic [HOLD_BITS-1:0] HOLD_LIMIT_RST  = 5'd16;
  localparam logic [THR_BITS-1:0]  STRONG_LOW_RST  = 10'd128;
  localparam logic [THR_BITS-1:0]  WEAK_LOW_RST    = 10'd320;
  localparam logic [THR_BITS-1:0]  WEAK_HIGH_RST   = 10'd704;
  localparam logic [THR_BITS-1:0]  STRONG_HIGH_RST = 10'd896;
  localparam logic [SAMPLE_BITS-1:0] AVG_RST       = SAMPLE_BITS'(512);

  // modes
  localparam logic [MODE_BITS-1:0] MODE_LETTERS = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_ARROWS  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_GAME    = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_SPELL   = 2'd3;

  // modifier bit positions
  localparam int MOD_CTRL  = 0;
  localparam int MOD_SHIFT = 1;

  // led pattern phase limits
  localparam logic [PHASE_BITS-1:0] PHASE_1000 = 13'd1000;
  localparam logic [PHASE_BITS-1:0] PHASE_3000 = 13'd3000;
  localparam logic [PHASE_BITS-1:0] PHASE_4000 = 13'd4000;

  // phase / 125 by reciprocal: exact for every 13-bit phase
  localparam int PULSE_SHIFT = 20;
  localparam int RECIP_BITS  = 14;
  localparam int PROD_BITS   = PHASE_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] PULSE_RECIP = 14'd8389;

  // joystick key codes
  localparam logic [KEY_BITS-1:0] KEY_D = 8'h07;
  localparam logic [KEY_BITS-1:0] KEY_A = 8'h04;
  localparam logic [KEY_BITS-1:0] KEY_W = 8'h1A;
  localparam logic [KEY_BITS-1:0] KEY_S = 8'h16;

  typedef struct packed {
    logic [THR_BITS-1:0] strong_low;
    logic [THR_BITS-1:0] weak_low;
    logic [THR_BITS-1:0] weak_high;
    logic [THR_BITS-1:0] strong_high;
  } thresh_t;

  typedef struct packed {
    logic low;
    logic high;
  } axis_req_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 led;
  } mode_state_t;

  // button pin scanned at each rank
  function automatic logic [1:0] button_pin(input logic [1:0] rank);
    logic [1:0] pin;
    case (rank)
      2'd0:    pin = 2'd2;
      2'd1:    pin = 2'd3;
      2'd2:    pin = 2'd1;
      default: pin = 2'd0;
    endcase
    return pin;
  endfunction

  function automatic logic [KEY_BITS-1:0] button_key(input logic [MODE_BITS-1:0] mode,
                                                     input logic [1:0] rank);
    logic [KEY_BITS-1:0] code;
    case ({mode, rank})
      4'h0:    code = 8'h0D;
      4'h1:    code = 8'h0C;
      4'h2:    code = 8'h0E;
      4'h3:    code = 8'h0F;
      4'h4:    code = 8'h50;
      4'h5:    code = 8'h52;
      4'h6:    code = 8'h51;
      4'h7:    code = 8'h4F;
      4'h8:    code = 8'h14;
      4'h9:    code = 8'h00;
      4'hA:    code = 8'h00;
      4'hB:    code = 8'h08;
      4'hC:    code = 8'h06;
      4'hD:    code = 8'h0A;
      4'hE:    code = 8'h2C;
      default: code = 8'h19;
    endcase
    return code;
  endfunction

  // odd 125 ms step within the phase
  function automatic logic phase_pulse(input logic [PHASE_BITS-1:0] phase);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(phase) * PROD_BITS'(PULSE_RECIP);
    return prod[PULSE_SHIFT];
  endfunction

endpackage
`default_nettype wire

[rtl/core/gamepad_keyboard_report_builder_core.sv]
`default_nettype none
// gamepad keyboard report builder: one keyboard report per poll. a poll item
// is captured in an input register; once the output register is free, the
// mode button hold counter, the two joystick averages and the key slot
// packing are worked out in one pass and the report lands in the output
// register, while the state is updated at the same edge. one poll item is
// taken every cycle while poll_stall is low. the rate is set by the single
// state update per item (mode counter and averages feed the next poll). the
// input register keeps taking items while a report waits in the output
// register, and the input stalls only when both registers are full and the
// waiting report is held off. the user must make configuration writes only
// while idle; the block itself does not enforce this.
module gamepad_keyboard_report_builder_core
  import gkrb_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration write port
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]   cfg_data,
  // poll items
  input  wire logic                       poll_valid,
  output logic                            poll_stall,
  input  wire logic [BUTTONS-1:0]         button_bits,
  input  wire logic                       mode_button_pressed,
  input  wire logic [SAMPLE_BITS-1:0]     horizontal_sample,
  input  wire logic [SAMPLE_BITS-1:0]     vertical_sample,
  input  wire logic [PHASE_BITS-1:0]      phase_ms,
  // report items
  output logic                            report_valid,
  input  wire logic                       report_stall,
  output logic [MOD_BITS-1:0]             modifier_bits,
  output logic [KEY_BITS-1:0]             key_slot_a,
  output logic [KEY_BITS-1:0]             key_slot_b,
  output logic [KEY_BITS-1:0]             key_slot_c,
  output logic [KEY_BITS-1:0]             key_slot_d,
  output logic [KEY_BITS-1:0]             key_slot_e,
  output logic [KEY_BITS-1:0]             key_slot_f,
  output logic                            led_on
);

  // configuration registers
  logic [HOLD_BITS-1:0] hold_limit;
  thresh_t              thresh;

  // input register
  logic                   in_full;
  logic [BUTTONS-1:0]     buttons;
  logic                   mode_pressed;
  logic [SAMPLE_BITS-1:0] h_sample;
  logic [SAMPLE_BITS-1:0] v_sample;
  logic [PHASE_BITS-1:0]  phase;

  // handshake
  logic out_free;
  logic advance;
  logic take;

  // per-item results
  logic                                pulse;
  mode_state_t                         mode_state;
  axis_req_t                           h_req;
  axis_req_t                           v_req;
  logic [MOD_BITS-1:0]                 modifier;
  logic [KEY_SLOTS-1:0][KEY_BITS-1:0]  slots;

  // output register
  logic [KEY_SLOTS-1:0][KEY_BITS-1:0]  slots_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit         <= HOLD_LIMIT_RST;
      thresh.strong_low  <= STRONG_LOW_RST;
      thresh.weak_low    <= WEAK_LOW_RST;
      thresh.weak_high   <= WEAK_HIGH_RST;
      thresh.strong_high <= STRONG_HIGH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HOLD_LIMIT:  hold_limit         <= cfg_data[HOLD_BITS-1:0];
        CFG_STRONG_LOW:  thresh.strong_low  <= cfg_data[THR_BITS-1:0];
        CFG_WEAK_LOW:    thresh.weak_low    <= cfg_data[THR_BITS-1:0];
        CFG_WEAK_HIGH:   thresh.weak_high   <= cfg_data[THR_BITS-1:0];
        CFG_STRONG_HIGH: thresh.strong_high <= cfg_data[THR_BITS-1:0];
        default:         hold_limit         <= hold_limit;
      endcase
    end
  end

  // output register free when empty or being taken this cycle
  assign out_free   = !report_valid || !report_stall;
  assign advance    = in_full && out_free;
  assign poll_stall = in_full && !out_free;
  assign take       = poll_valid && !poll_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      report_valid <= 1'b0;
    end else begin
      in_full      <= take || (in_full && !advance);
      report_valid <= advance || (report_valid && report_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buttons      <= button_bits;
      mode_pressed <= mode_button_pressed;
      h_sample     <= horizontal_sample;
      v_sample     <= vertical_sample;
      phase        <= phase_ms;
    end
  end

  assign pulse = phase_pulse(phase);

  gkrb_mode_ctrl u_mode_ctrl (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .pressed    (mode_pressed),
    .phase      (phase),
    .hold_limit (hold_limit),
    .state_next (mode_state)
  );

  gkrb_axis_filter u_axis_h (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .sample (h_sample),
    .pulse  (pulse),
    .thresh (thresh),
    .req    (h_req)
  );

  gkrb_axis_filter u_axis_v (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .sample (v_sample),
    .pulse  (pulse),
    .thresh (thresh),
    .req    (v_req)
  );

  gkrb_key_pack u_key_pack (
    .mode     (mode_state.mode),
    .buttons  (buttons),
    .horiz    (h_req),
    .vert     (v_req),
    .modifier (modifier),
    .slots    (slots)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      modifier_bits <= modifier;
      slots_out     <= slots;
      led_on        <= mode_state.led;
    end
  end

  assign key_slot_a = slots_out[0];
  assign key_slot_b = slots_out[1];
  assign key_slot_c = slots_out[2];
  assign key_slot_d = slots_out[3];
  assign key_slot_e = slots_out[4];
  assign key_slot_f = slots_out[5];

endmodule
`default_nettype wire

[rtl/core/gkrb_mode_ctrl.sv]
`default_nettype none
module gkrb_mode_ctrl
  import gkrb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  pressed,
  input  wire logic [PHASE_BITS-1:0] phase,
  input  wire logic [HOLD_BITS-1:0]  hold_limit,
  output mode_state_t                state_next
);

  logic [MODE_BITS-1:0] mode, mode_next;
  logic [HOLD_BITS-1:0] hold_count, hold_count_next;
  logic                 latched, latched_next;
  logic                 locked, locked_next;
  logic                 led, led_next;
  logic [HOLD_BITS:0]   inc;

  always_comb begin
    mode_next       = mode;
    hold_count_next = hold_count;
    latched_next    = latched;
    locked_next     = locked;
    led_next        = led;
    inc             = {1'b0, hold_count} + (HOLD_BITS + 1)'(1);

    if (pressed) begin
      if (inc > {1'b0, hold_limit}) begin
        hold_count_next = hold_limit;
        if (!latched) begin
          if (!locked) begin
            led_next = 1'b1;
          end
          locked_next  = 1'b1;
          mode_next    = mode + MODE_BITS'(1);
          latched_next = 1'b1;
        end
      end else begin
        hold_count_next = inc[HOLD_BITS-1:0];
      end
    end else if (hold_count != '0) begin
      hold_count_next = hold_count - HOLD_BITS'(1);
      if (hold_count_next == '0) begin
        locked_next  = 1'b0;
        led_next     = 1'b0;
        latched_next = 1'b0;
      end
    end

    // blink pattern of the mode, held off while locked
    if (!locked_next) begin
      case (mode_next)
        MODE_ARROWS: led_next = (phase < PHASE_1000);
        MODE_GAME:   led_next = (phase < PHASE_1000) ||
                                ((phase > PHASE_3000) && (phase < PHASE_4000));
        MODE_SPELL:  led_next = (phase < PHASE_3000);
        default:     led_next = led_next;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_LETTERS;
      hold_count <= '0;
      latched    <= 1'b0;
      locked     <= 1'b0;
      led        <= 1'b0;
    end else if (en) begin
      mode       <= mode_next;
      hold_count <= hold_count_next;
      latched    <= latched_next;
      locked     <= locked_next;
      led        <= led_next;
    end
  end

  assign state_next.mode = mode_next;
  assign state_next.led  = led_next;

endmodule
`default_nettype wire

[rtl/core/gkrb_axis_filter.sv]
`default_nettype none
module gkrb_axis_filter
  import gkrb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   pulse,
  input  thresh_t                     thresh,
  output axis_req_t                   req
);

  logic [SAMPLE_BITS-1:0] avg, avg_next;
  logic [CMP_BITS-1:0]    avg_cmp;

  // halving running average
  assign avg_next = (avg >> 1) + (sample >> 1);
  assign avg_cmp  = CMP_BITS'(avg_next);

  assign req.low  = (avg_cmp < CMP_BITS'(thresh.strong_low)) ||
                    ((avg_cmp < CMP_BITS'(thresh.weak_low)) && pulse);
  assign req.high = (avg_cmp > CMP_BITS'(thresh.strong_high)) ||
                    ((avg_cmp > CMP_BITS'(thresh.weak_high)) && pulse);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= AVG_RST;
    end else if (en) begin
      avg <= avg_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/gkrb_key_pack.sv]
`default_nettype none
module gkrb_key_pack
  import gkrb_pkg::*;
(
  input  wire logic [MODE_BITS-1:0]               mode,
  input  wire logic [BUTTONS-1:0]                 buttons,
  input  axis_req_t                               horiz,
  input  axis_req_t                               vert,
  output logic [MOD_BITS-1:0]                     modifier,
  output logic [KEY_SLOTS-1:0][KEY_BITS-1:0]      slots
);

  logic [USED_BITS-1:0]                 used;
  logic [AXIS_REQS-1:0]                 axis_want;
  logic [AXIS_REQS-1:0][KEY_BITS-1:0]   axis_code;

  assign axis_want = {vert.high, vert.low, horiz.high, horiz.low};
  assign axis_code = {KEY_S, KEY_W, KEY_A, KEY_D};

  always_comb begin
    modifier = '0;
    slots    = '0;
    used     = '0;
    for (int r = 0; r < BUTTONS; r++) begin
      if (buttons[button_pin(2'(r))]) begin
        if (mode == MODE_GAME && r == 1) begin
          modifier[MOD_SHIFT] = 1'b1;
        end else if (mode == MODE_GAME && r == 2) begin
          modifier[MOD_CTRL] = 1'b1;
        end else if (used < USED_BITS'(KEY_SLOTS)) begin
          slots[used[SLOT_IDX_BITS-1:0]] = button_key(mode, 2'(r));
          used = used + USED_BITS'(1);
        end
      end
    end
    // joystick keys follow, extra keys dropped once the slots are full
    for (int k = 0; k < AXIS_REQS; k++) begin
      if (axis_want[k] && used < USED_BITS'(KEY_SLOTS)) begin
        slots[used[SLOT_IDX_BITS-1:0]] = axis_code[k];
        used = used + USED_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire
